@@ hw/rtl/oven_timer_controller_defines.svh @@
// assertion macros shared by the oven timer controller rtl
`ifndef OVEN_TIMER_CONTROLLER_DEFINES_SVH
`define OVEN_TIMER_CONTROLLER_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication, checked out of reset
`define OTC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
// next-cycle implication, checked out of reset
`define OTC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define OTC_ASSERT_IMP(lbl, ante, cons)
`define OTC_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

@@ hw/rtl/otc_pkg.sv @@
// types and constants of the oven timer controller
`default_nettype none

package otc_pkg;

  localparam int MAX_DIGITS = 2;

  localparam int DUR_W      = 7;
  localparam int HOLD_W     = 6;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DURATION = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ERROR_HOLD   = 1'd1;

  localparam logic [DUR_W-1:0]  MAX_DURATION_RST = 7'd60;
  localparam logic [HOLD_W-1:0] ERROR_HOLD_RST   = 6'd3;
  localparam logic [DUR_W-1:0]  DURATION_CAP     = 7'd99;
  localparam logic [DUR_W-1:0]  COUNT_SAT        = 7'd127;

  localparam logic [7:0] ASCII_0  = 8'h30;
  localparam logic [7:0] ASCII_9  = 8'h39;
  localparam logic [7:0] ASCII_CR = 8'h0d;
  localparam logic [7:0] ASCII_LF = 8'h0a;

  localparam logic [2:0] LAMP_GREEN  = 3'b001;
  localparam logic [2:0] LAMP_YELLOW = 3'b010;
  localparam logic [2:0] LAMP_RED    = 3'b100;

  typedef enum logic [1:0] {
    MODE_WAIT = 2'd0,
    MODE_COOK = 2'd1,
    MODE_TERR = 2'd2,
    MODE_DERR = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    MSG_NONE       = 3'd0,
    MSG_ENTER      = 3'd1,
    MSG_COOK_START = 3'd2,
    MSG_INVALID    = 3'd3,
    MSG_CLOSE_DOOR = 3'd4
  } msg_t;

  typedef struct packed {
    logic       stop_button;
    logic       door_input;
    logic       byte_valid;
    logic [7:0] rx_byte;
    logic       second_tick;
  } otc_in_t;

  typedef struct packed {
    mode_t            mode;
    logic             led_green;
    logic             led_yellow;
    logic             led_red;
    msg_t             message;
    logic [DUR_W-1:0] cook_seconds;
  } otc_out_t;

endpackage

`default_nettype wire

@@ hw/rtl/otc_chan_if.sv @@
// input and result channel interfaces of the oven timer controller
`default_nettype none

interface otc_in_if;
  logic       valid;
  logic       ready;
  logic       stop_button;
  logic       door_input;
  logic       byte_valid;
  logic [7:0] rx_byte;
  logic       second_tick;

  modport source (output valid, stop_button, door_input, byte_valid, rx_byte, second_tick,
                  input ready);
  modport sink   (input valid, stop_button, door_input, byte_valid, rx_byte, second_tick,
                  output ready);
endinterface

interface otc_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic       led_green;
  logic       led_yellow;
  logic       led_red;
  logic [2:0] message;
  logic [6:0] cook_seconds;

  modport source (output valid, mode, led_green, led_yellow, led_red, message, cook_seconds,
                  input ready);
  modport sink   (input valid, mode, led_green, led_yellow, led_red, message, cook_seconds,
                  output ready);
endinterface

`default_nettype wire

@@ hw/rtl/otc_in_reg.sv @@
// input register stage of the oven timer controller
`default_nettype none

module otc_in_reg (
  input  wire logic            clk,
  input  wire logic            rst_n,
  otc_in_if.sink               in_if,
  input  wire logic            adv,
  output logic                 valid_r,
  output otc_pkg::otc_in_t     data_r
);

  logic accept;

  // free slot, or the held word leaves this cycle
  assign in_if.ready = !valid_r || adv;
  assign accept      = in_if.valid && in_if.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (accept) begin
      valid_r <= 1'b1;
    end else if (adv) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      data_r.stop_button <= in_if.stop_button;
      data_r.door_input  <= in_if.door_input;
      data_r.byte_valid  <= in_if.byte_valid;
      data_r.rx_byte     <= in_if.rx_byte;
      data_r.second_tick <= in_if.second_tick;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/otc_ctrl.sv @@
// mode, entry and timer state with its single-pass update
`default_nettype none

module otc_ctrl #(
  parameter int MAX_DIGITS = otc_pkg::MAX_DIGITS
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [otc_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [otc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                           step,
  input  wire otc_pkg::otc_in_t               item,
  output otc_pkg::otc_out_t                   result
);

  localparam int DCW = $clog2(MAX_DIGITS + 1);
  localparam int DW  = otc_pkg::DUR_W;

  logic [DW-1:0]              max_dur_r;
  logic [otc_pkg::HOLD_W-1:0] hold_r;

  otc_pkg::mode_t mode_r, mode_nxt;
  logic [DCW-1:0] dig_cnt_r, dig_cnt_nxt;
  logic [DW-1:0]  code_r, code_nxt;
  logic           stop_prev_r, door_prev_r;
  logic [DW-1:0]  tmr_cnt_r, tmr_cnt_nxt;
  logic [DW-1:0]  tmr_per_r, tmr_per_nxt;
  logic           tmr_run_r, tmr_run_nxt;
  logic           tmr_exp_r, tmr_exp_nxt;
  logic [2:0]     lamp_r, lamp_nxt;

  logic           stop_rise, door_rise;
  logic [DW-1:0]  cnt_inc;
  logic           is_digit, is_eol;
  logic [DW-1:0]  base;
  logic [10:0]    acc;
  logic [DW-1:0]  code_sat, code_new;
  logic [DCW-1:0] dig_cnt_inc;
  logic           done;
  logic [DW-1:0]  limit;
  otc_pkg::msg_t  msg;
  logic [DW-1:0]  cook_sec;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_dur_r <= otc_pkg::MAX_DURATION_RST;
      hold_r    <= otc_pkg::ERROR_HOLD_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        otc_pkg::CFG_MAX_DURATION: max_dur_r <= cfg_wdata[DW-1:0];
        otc_pkg::CFG_ERROR_HOLD:   hold_r    <= cfg_wdata[otc_pkg::HOLD_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= otc_pkg::MODE_WAIT;
      dig_cnt_r   <= '0;
      code_r      <= '0;
      stop_prev_r <= 1'b0;
      door_prev_r <= 1'b0;
      tmr_cnt_r   <= '0;
      tmr_per_r   <= '0;
      tmr_run_r   <= 1'b0;
      tmr_exp_r   <= 1'b0;
      lamp_r      <= otc_pkg::LAMP_GREEN;
    end else if (step) begin
      mode_r      <= mode_nxt;
      dig_cnt_r   <= dig_cnt_nxt;
      code_r      <= code_nxt;
      stop_prev_r <= item.stop_button;
      door_prev_r <= item.door_input;
      tmr_cnt_r   <= tmr_cnt_nxt;
      tmr_per_r   <= tmr_per_nxt;
      tmr_run_r   <= tmr_run_nxt;
      tmr_exp_r   <= tmr_exp_nxt;
      lamp_r      <= lamp_nxt;
    end
  end

  assign stop_rise = item.stop_button && !stop_prev_r;
  assign door_rise = item.door_input && !door_prev_r;
  assign cnt_inc   = (tmr_cnt_r != otc_pkg::COUNT_SAT) ? tmr_cnt_r + 1'b1 : tmr_cnt_r;

  assign is_digit = (item.rx_byte >= otc_pkg::ASCII_0) && (item.rx_byte <= otc_pkg::ASCII_9);
  assign is_eol   = (item.rx_byte == otc_pkg::ASCII_CR) || (item.rx_byte == otc_pkg::ASCII_LF);

  // value times ten plus the new digit, saturating at 127
  assign base     = (dig_cnt_r == '0) ? '0 : code_r;
  assign acc      = {1'b0, base, 3'b000} + {3'b000, base, 1'b0} + {7'd0, item.rx_byte[3:0]};
  assign code_sat = (acc > 11'(otc_pkg::COUNT_SAT)) ? otc_pkg::COUNT_SAT : acc[DW-1:0];
  assign code_new = (item.byte_valid && is_digit) ? code_sat : code_r;

  assign dig_cnt_inc = dig_cnt_r + 1'b1;
  assign done = item.byte_valid &&
                ((is_eol && dig_cnt_r != '0) ||
                 (is_digit && dig_cnt_inc >= DCW'(MAX_DIGITS)));

  assign limit = (max_dur_r > otc_pkg::DURATION_CAP) ? otc_pkg::DURATION_CAP : max_dur_r;

  always_comb begin
    mode_nxt    = mode_r;
    dig_cnt_nxt = dig_cnt_r;
    code_nxt    = code_r;
    tmr_cnt_nxt = tmr_cnt_r;
    tmr_per_nxt = tmr_per_r;
    tmr_run_nxt = tmr_run_r;
    tmr_exp_nxt = tmr_exp_r;
    lamp_nxt    = lamp_r;
    msg         = otc_pkg::MSG_NONE;
    cook_sec    = '0;

    // timer advances first, on the state from before this word
    if (tmr_run_r && item.second_tick) begin
      tmr_cnt_nxt = cnt_inc;
      if (cnt_inc >= tmr_per_r) begin
        tmr_exp_nxt = 1'b1;
        tmr_run_nxt = 1'b0;
      end
    end

    case (mode_r)
      otc_pkg::MODE_WAIT: begin
        if (item.byte_valid && is_digit) begin
          code_nxt    = code_sat;
          dig_cnt_nxt = dig_cnt_inc;
        end
        if (done) begin
          dig_cnt_nxt = '0;
          if (code_new != '0 && code_new <= limit) begin
            if (item.door_input) begin
              mode_nxt    = otc_pkg::MODE_COOK;
              tmr_cnt_nxt = '0;
              tmr_per_nxt = code_new;
              tmr_run_nxt = 1'b1;
              tmr_exp_nxt = 1'b0;
              lamp_nxt    = otc_pkg::LAMP_YELLOW;
              msg         = otc_pkg::MSG_COOK_START;
              cook_sec    = code_new;
            end else begin
              mode_nxt = otc_pkg::MODE_DERR;
              lamp_nxt = otc_pkg::LAMP_RED;
              msg      = otc_pkg::MSG_CLOSE_DOOR;
            end
          end else begin
            mode_nxt    = otc_pkg::MODE_TERR;
            tmr_cnt_nxt = '0;
            tmr_per_nxt = {1'b0, hold_r};
            tmr_run_nxt = 1'b1;
            tmr_exp_nxt = 1'b0;
            lamp_nxt    = otc_pkg::LAMP_RED;
            msg         = otc_pkg::MSG_INVALID;
          end
        end
      end
      otc_pkg::MODE_COOK, otc_pkg::MODE_TERR: begin
        if (tmr_exp_nxt || (mode_r == otc_pkg::MODE_COOK && (stop_rise || door_rise))) begin
          mode_nxt    = otc_pkg::MODE_WAIT;
          dig_cnt_nxt = '0;
          code_nxt    = '0;
          tmr_cnt_nxt = '0;
          tmr_run_nxt = 1'b0;
          tmr_exp_nxt = 1'b0;
          lamp_nxt    = otc_pkg::LAMP_GREEN;
          msg         = otc_pkg::MSG_ENTER;
        end
      end
      otc_pkg::MODE_DERR: begin
        if (door_rise) begin
          mode_nxt    = otc_pkg::MODE_COOK;
          tmr_cnt_nxt = '0;
          tmr_per_nxt = code_r;
          tmr_run_nxt = 1'b1;
          tmr_exp_nxt = 1'b0;
          lamp_nxt    = otc_pkg::LAMP_YELLOW;
          msg         = otc_pkg::MSG_COOK_START;
          cook_sec    = code_r;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    result.mode         = mode_nxt;
    result.led_green    = (lamp_nxt & otc_pkg::LAMP_GREEN) != 3'b000;
    result.led_yellow   = (lamp_nxt & otc_pkg::LAMP_YELLOW) != 3'b000;
    result.led_red      = (lamp_nxt & otc_pkg::LAMP_RED) != 3'b000;
    result.message      = msg;
    result.cook_seconds = cook_sec;
  end

endmodule

`default_nettype wire

@@ hw/rtl/otc_out_reg.sv @@
// result register stage of the oven timer controller
`default_nettype none

module otc_out_reg (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              load,
  input  wire otc_pkg::otc_out_t data,
  output logic                   can_take,
  output logic                   valid_r,
  otc_out_if.source              out_if
);

  otc_pkg::otc_out_t data_r;

  // empty, or the held word is taken this cycle
  assign can_take = !valid_r || out_if.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_if.ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= data;
    end
  end

  assign out_if.valid        = valid_r;
  assign out_if.mode         = 2'(data_r.mode);
  assign out_if.led_green    = data_r.led_green;
  assign out_if.led_yellow   = data_r.led_yellow;
  assign out_if.led_red      = data_r.led_red;
  assign out_if.message      = 3'(data_r.message);
  assign out_if.cook_seconds = data_r.cook_seconds;

endmodule

`default_nettype wire

@@ hw/rtl/oven_timer_controller.sv @@
// oven timer controller top level
//
// in_if carries one sampled word per handshake: button and door levels, an
// optional received byte and a one-second tick. out_if returns exactly one
// word per input word: mode, the three lamps, a message code and the cook
// duration that goes with the cooking-started message.
// cfg_we with cfg_idx writes max_duration (0) or error_hold_seconds (1);
// write only while no word is in flight.
// a word accepted into the input register is updated into the result register
// when it advances, and its result is then offered on out_if.
// throughput: one word per cycle while out_if does not stall, set by the single
// update pass between the input register and the result register.
// when out_if stalls the result register holds, the input register still
// takes one more word, then in_if.ready drops until the result is taken.
// synchronous reset: mode waiting, green lamp, no digits, timer stopped,
// both stored levels low, registers back to 60 and 3 seconds; both
// stages come out of reset empty.
`default_nettype none

`include "oven_timer_controller_defines.svh"

module oven_timer_controller #(
  parameter int MAX_DIGITS = otc_pkg::MAX_DIGITS
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  otc_in_if.sink                              in_if,
  otc_out_if.source                           out_if,
  input  wire logic                           cfg_we,
  input  wire logic [otc_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [otc_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  logic              in_valid_r;   // input register holds a word
  otc_pkg::otc_in_t  in_data_r;
  logic              out_can_take; // result register can load this cycle
  logic              out_valid_r;
  logic              adv;          // word moves from input to result register
  otc_pkg::otc_out_t result;

  assign adv = in_valid_r && out_can_take;

  otc_in_reg u_in_reg (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (in_if),
    .adv     (adv),
    .valid_r (in_valid_r),
    .data_r  (in_data_r)
  );

  // mode, entry and timer state only change when a word passes through
  otc_ctrl #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .step      (adv),
    .item      (in_data_r),
    .result    (result)
  );

  otc_out_reg u_out_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (adv),
    .data     (result),
    .can_take (out_can_take),
    .valid_r  (out_valid_r),
    .out_if   (out_if)
  );

  // exactly one lamp lit in every result
  `OTC_ASSERT_IMP(a_one_lamp, out_valid_r,
                  $onehot({out_if.led_green, out_if.led_yellow, out_if.led_red}))
  // cooking-started carries a nonzero duration and cooking mode
  `OTC_ASSERT_IMP(a_cook_msg, out_valid_r && out_if.message == otc_pkg::MSG_COOK_START,
                  out_if.mode == otc_pkg::MODE_COOK && out_if.cook_seconds != 7'd0)
  // both stages full and stalled means no new word
  `OTC_ASSERT_IMP(a_full_stall, in_valid_r && out_valid_r && !out_if.ready, !in_if.ready)
  // a word that advances shows up as a result
  `OTC_ASSERT_NXT(a_adv_out, adv, out_valid_r)

endmodule

`default_nettype wire
